/* rtl/tqs_pkg.sv */
package tqs_pkg;

   localparam int TASK_BITS   = 6;
   localparam int MAX_TASKS   = 1 << TASK_BITS;
   localparam int COUNT_BITS  = $clog2(MAX_TASKS + 1);
   localparam int SLICE_BITS  = 8;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   typedef logic [TASK_BITS-1:0]  task_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [SLICE_BITS-1:0] slice_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PICK    = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_QUEUED     = 2'd1,
      STATUS_NOT_QUEUED = 2'd2,
      STATUS_EMPTY      = 2'd3
   } status_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } state_type;

   // outcome of the shared slice compare / increment unit
   typedef struct packed {
      logic      exhausted;
      slice_type next_slice;
   } slice_res_type;

endpackage

/* rtl/tqs_ram.sv */
module tqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tqs_slice_unit.sv */
module tqs_slice_unit (
   input  tqs_pkg::slice_type     used,
   input  tqs_pkg::slice_type     limit,
   output tqs_pkg::slice_res_type res
);

   logic               below;
   tqs_pkg::slice_type used_inc;

   // one compare serves both the enqueue placement and the tick saturation
   assign below    = used < limit;
   assign used_inc = used + tqs_pkg::slice_type'(1);

   assign res.exhausted  = ~below;
   assign res.next_slice = below ? used_inc : used;

endmodule

/* rtl/two_queue_slice_scheduler_unit.sv */
// two-queue slice scheduler: a running and an exhausted fifo of task ids kept as doubly
// linked lists in three small rams (next link, previous link, owning queue), with a
// queued mark per task in flip-flops that reset clears at once, so no clearing pass is
// needed. a request is taken when start is high and busy is low; busy then stays high
// through the execute cycle, and the single response appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, in the cycle after that. a new request may be
// accepted in the same cycle the previous response is shown: the link rams are read on
// the acceptance edge and all list updates are written in the execute cycle. the
// receiver cannot stall the response, so it must sample rsp_ports whenever rsp_valid is
// high. pick returns the head of the running queue without removing it, swapping the
// queue roles first if the running queue is empty (status empty if both are); tick
// reports the incremented slice, held unchanged once it reaches priority.
module two_queue_slice_scheduler_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [tqs_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [tqs_pkg::TASK_BITS-1:0]    req_task_id,
   input  logic [tqs_pkg::SLICE_BITS-1:0]   req_priority_req,
   input  logic [tqs_pkg::SLICE_BITS-1:0]   req_used_slice,
   // response channel
   output logic                             rsp_valid,
   output logic [tqs_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [tqs_pkg::TASK_BITS-1:0]    rsp_picked_task,
   output logic                             rsp_to_exhausted,
   output logic [tqs_pkg::SLICE_BITS-1:0]   rsp_new_slice,
   output logic                             rsp_yielded,
   output logic [tqs_pkg::COUNT_BITS-1:0]   rsp_queued_total
);

   // sequencer
   tqs_pkg::state_type state_ff, state_in;

   // latched request
   tqs_pkg::cmd_type   cmd_ff, cmd_in;
   tqs_pkg::task_type  task_ff, task_in;
   tqs_pkg::slice_type prio_ff, prio_in;
   tqs_pkg::slice_type used_ff, used_in;

   // queue bookkeeping
   logic [tqs_pkg::MAX_TASKS-1:0] queued_ff, queued_in;
   tqs_pkg::task_type  head_ff [2];
   tqs_pkg::task_type  head_in [2];
   tqs_pkg::task_type  tail_ff [2];
   tqs_pkg::task_type  tail_in [2];
   tqs_pkg::count_type len_ff [2];
   tqs_pkg::count_type len_in [2];
   logic               run_sel_ff, run_sel_in;
   tqs_pkg::count_type total_ff, total_in;

   // response registers
   logic                  valid_ff, valid_in;
   tqs_pkg::status_type   status_ff, status_in;
   tqs_pkg::task_type     picked_ff, picked_in;
   logic                  to_exh_ff, to_exh_in;
   tqs_pkg::slice_type    nslice_ff, nslice_in;
   logic                  yld_ff, yld_in;
   tqs_pkg::count_type    qtotal_ff, qtotal_in;

   // link ram ports
   logic              next_we, prev_we, qsel_we;
   tqs_pkg::task_type next_waddr, next_wdata, next_rdata;
   tqs_pkg::task_type prev_waddr, prev_wdata, prev_rdata;
   tqs_pkg::task_type qsel_waddr;
   logic [0:0]        qsel_wdata, qsel_rdata;

   // shared slice unit
   tqs_pkg::slice_res_type slice_res;

   // helpers for the execute cycle
   logic enq_q;
   logic deq_q;
   logic deq_at_head;
   logic deq_at_tail;
   logic run_empty;
   logic other_empty;

   tqs_slice_unit u_slice (
      .used  (used_ff),
      .limit (prio_ff),
      .res   (slice_res)
   );

   // links are read on the acceptance edge, data valid in the execute cycle
   tqs_ram #(
      .WIDTH (tqs_pkg::TASK_BITS),
      .DEPTH (tqs_pkg::MAX_TASKS)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (req_task_id),
      .rd_data (next_rdata)
   );

   tqs_ram #(
      .WIDTH (tqs_pkg::TASK_BITS),
      .DEPTH (tqs_pkg::MAX_TASKS)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (req_task_id),
      .rd_data (prev_rdata)
   );

   tqs_ram #(
      .WIDTH (1),
      .DEPTH (tqs_pkg::MAX_TASKS)
   ) u_qsel_ram (
      .clock   (clock),
      .wr_en   (qsel_we),
      .wr_addr (qsel_waddr),
      .wr_data (qsel_wdata),
      .rd_addr (req_task_id),
      .rd_data (qsel_rdata)
   );

   // exhausted tasks go to the queue that is not running
   assign enq_q       = run_sel_ff ^ slice_res.exhausted;
   assign deq_q       = qsel_rdata[0];
   assign deq_at_head = head_ff[deq_q] == task_ff;
   assign deq_at_tail = tail_ff[deq_q] == task_ff;
   assign run_empty   = len_ff[run_sel_ff] == '0;
   assign other_empty = len_ff[~run_sel_ff] == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tqs_pkg::STATE_IDLE;
         valid_ff   <= 1'b0;
         queued_ff  <= '0;
         head_ff    <= '{default: '0};
         tail_ff    <= '{default: '0};
         len_ff     <= '{default: '0};
         run_sel_ff <= 1'b0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         queued_ff  <= queued_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         len_ff     <= len_in;
         run_sel_ff <= run_sel_in;
         total_ff   <= total_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      task_ff   <= task_in;
      prio_ff   <= prio_in;
      used_ff   <= used_in;
      status_ff <= status_in;
      picked_ff <= picked_in;
      to_exh_ff <= to_exh_in;
      nslice_ff <= nslice_in;
      yld_ff    <= yld_in;
      qtotal_ff <= qtotal_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      task_in    = task_ff;
      prio_in    = prio_ff;
      used_in    = used_ff;
      queued_in  = queued_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      len_in     = len_ff;
      run_sel_in = run_sel_ff;
      total_in   = total_ff;
      valid_in   = 1'b0;
      status_in  = status_ff;
      picked_in  = picked_ff;
      to_exh_in  = to_exh_ff;
      nslice_in  = nslice_ff;
      yld_in     = yld_ff;
      qtotal_in  = qtotal_ff;
      next_we    = 1'b0;
      next_waddr = task_ff;
      next_wdata = task_ff;
      prev_we    = 1'b0;
      prev_waddr = task_ff;
      prev_wdata = task_ff;
      qsel_we    = 1'b0;
      qsel_waddr = task_ff;
      qsel_wdata = enq_q;

      case (state_ff)
         tqs_pkg::STATE_IDLE: begin
            if (start) begin
               cmd_in   = tqs_pkg::cmd_type'(req_cmd);
               task_in  = req_task_id;
               prio_in  = req_priority_req;
               used_in  = req_used_slice;
               state_in = tqs_pkg::STATE_EXEC;
            end
         end
         tqs_pkg::STATE_EXEC: begin
            state_in  = tqs_pkg::STATE_IDLE;
            valid_in  = 1'b1;
            status_in = tqs_pkg::STATUS_OK;
            picked_in = '0;
            to_exh_in = 1'b0;
            nslice_in = '0;
            yld_in    = 1'b0;
            case (cmd_ff)
               tqs_pkg::CMD_ENQUEUE: begin
                  if (queued_ff[task_ff]) begin
                     status_in = tqs_pkg::STATUS_QUEUED;
                  end else begin
                     if (len_ff[enq_q] == '0) begin
                        head_in[enq_q] = task_ff;
                     end else begin
                        // link old tail to the new task
                        next_we    = 1'b1;
                        next_waddr = tail_ff[enq_q];
                        next_wdata = task_ff;
                        prev_we    = 1'b1;
                        prev_waddr = task_ff;
                        prev_wdata = tail_ff[enq_q];
                     end
                     tail_in[enq_q]     = task_ff;
                     len_in[enq_q]      = len_ff[enq_q] + tqs_pkg::count_type'(1);
                     qsel_we            = 1'b1;
                     queued_in[task_ff] = 1'b1;
                     total_in           = total_ff + tqs_pkg::count_type'(1);
                     to_exh_in          = slice_res.exhausted;
                  end
               end
               tqs_pkg::CMD_DEQUEUE: begin
                  if (!queued_ff[task_ff]) begin
                     status_in = tqs_pkg::STATUS_NOT_QUEUED;
                  end else begin
                     if (deq_at_head) begin
                        head_in[deq_q] = next_rdata;
                     end else begin
                        next_we    = 1'b1;
                        next_waddr = prev_rdata;
                        next_wdata = next_rdata;
                     end
                     if (deq_at_tail) begin
                        tail_in[deq_q] = prev_rdata;
                     end else begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rdata;
                        prev_wdata = prev_rdata;
                     end
                     if (len_ff[deq_q] != '0) begin
                        len_in[deq_q] = len_ff[deq_q] - tqs_pkg::count_type'(1);
                     end
                     if (total_ff != '0) begin
                        total_in = total_ff - tqs_pkg::count_type'(1);
                     end
                     queued_in[task_ff] = 1'b0;
                  end
               end
               tqs_pkg::CMD_PICK: begin
                  if (!run_empty) begin
                     picked_in = head_ff[run_sel_ff];
                  end else if (!other_empty) begin
                     // running queue drained: exhausted queue takes over
                     run_sel_in = ~run_sel_ff;
                     picked_in  = head_ff[~run_sel_ff];
                  end else begin
                     status_in = tqs_pkg::STATUS_EMPTY;
                  end
               end
               tqs_pkg::CMD_TICK: begin
                  nslice_in = slice_res.next_slice;
                  yld_in    = 1'b1;
               end
               default: begin
                  status_in = tqs_pkg::STATUS_OK;
               end
            endcase
            qtotal_in = total_in;
         end
         default: begin
            state_in = tqs_pkg::STATE_IDLE;
         end
      endcase
   end

   assign busy             = state_ff == tqs_pkg::STATE_EXEC;
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_picked_task  = picked_ff;
   assign rsp_to_exhausted = to_exh_ff;
   assign rsp_new_slice    = nslice_ff;
   assign rsp_yielded      = yld_ff;
   assign rsp_queued_total = qtotal_ff;

`ifndef NO_ASSERTIONS
   // a response only ever follows an execute cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == tqs_pkg::STATE_EXEC))
      else $error("response without execute cycle");

   // an accepted request always occupies the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start execution");

   // total count tracks the two queue lengths
   a_total_sum: assert property (@(posedge clock) disable iff (reset)
      total_ff == tqs_pkg::count_type'(len_ff[0] + len_ff[1]))
      else $error("total count differs from queue lengths");

   // queued marks agree with the total count
   a_marks_total: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) == total_ff)
      else $error("queued marks differ from total count");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tqs_pkg::*;

   // cycles with neither a request taken nor a response shown before giving up
   localparam int WATCHDOG_LIMIT = 500;
   // quiet cycles after the last response
   localparam int DRAIN_CYCLES   = 8;

   // one predicted response, field for field as on the rsp_ ports
   typedef struct {
      status_type status;
      task_type   picked_task;
      logic       to_exhausted;
      slice_type  new_slice;
      logic       yielded;
      count_type  queued_total;
   } sched_outcome_type;

   // clock, reset and request side, all known from time zero
   logic      clock            = 1'b0;
   logic      reset            = 1'b1;
   logic      start            = 1'b0;
   logic [CMD_BITS-1:0] req_cmd = '0;
   task_type  req_task_id      = '0;
   slice_type req_priority_req = '0;
   slice_type req_used_slice   = '0;

   // response side
   logic                   busy;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   task_type               rsp_picked_task;
   logic                   rsp_to_exhausted;
   slice_type              rsp_new_slice;
   logic                   rsp_yielded;
   count_type              rsp_queued_total;

   // shadow copy of the scheduler: links, queued marks, owning list per task
   task_type  link_fwd    [MAX_TASKS];
   task_type  link_back   [MAX_TASKS];
   logic      task_queued [MAX_TASKS];
   logic      task_home   [MAX_TASKS];
   task_type  list_head   [2];
   task_type  list_tail   [2];
   count_type list_len    [2];
   logic      active_list;
   count_type tasks_held;

   // responses still owed by the block, oldest first
   sched_outcome_type pending_outcomes[$];

   int  mismatch_count = 0;
   int  stalled_cycles = 0;
   bit  idle_enable    = 1'b1;

   two_queue_slice_scheduler_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .req_used_slice   (req_used_slice),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_picked_task  (rsp_picked_task),
      .rsp_to_exhausted (rsp_to_exhausted),
      .rsp_new_slice    (rsp_new_slice),
      .rsp_yielded      (rsp_yielded),
      .rsp_queued_total (rsp_queued_total)
   );

   always #6 clock = ~clock;

   // shadow state after reset: nothing queued, list zero running
   task automatic clear_shadow();
      for (int k = 0; k < MAX_TASKS; k++) begin
         link_fwd[k]    = '0;
         link_back[k]   = '0;
         task_queued[k] = 1'b0;
         task_home[k]   = 1'b0;
      end
      for (int q = 0; q < 2; q++) begin
         list_head[q] = '0;
         list_tail[q] = '0;
         list_len[q]  = '0;
      end
      active_list = 1'b0;
      tasks_held  = '0;
   endtask

   // applies one request to the shadow lists and returns the response it owes
   function automatic sched_outcome_type predict_outcome(cmd_type cmd, task_type id,
                                                         slice_type prio, slice_type used);
      sched_outcome_type res;
      logic              dest;
      logic              home;
      task_type          nx;
      task_type          pv;
      res = '{STATUS_OK, '0, 1'b0, '0, 1'b0, '0};
      case (cmd)
         CMD_ENQUEUE: begin
            if (task_queued[id]) begin
               res.status = STATUS_QUEUED;
            end else begin
               // a slice at or past its allowance goes to the exhausted list
               dest = (used >= prio) ? ~active_list : active_list;
               if (list_len[dest] == 0) begin
                  list_head[dest] = id;
               end else begin
                  link_fwd[list_tail[dest]] = id;
                  link_back[id] = list_tail[dest];
               end
               list_tail[dest]  = id;
               list_len[dest]   = list_len[dest] + 1'b1;
               task_home[id]    = dest;
               task_queued[id]  = 1'b1;
               tasks_held       = tasks_held + 1'b1;
               res.to_exhausted = (used >= prio);
            end
         end
         CMD_DEQUEUE: begin
            if (!task_queued[id]) begin
               res.status = STATUS_NOT_QUEUED;
            end else begin
               // unlink from head, middle or tail of whichever list holds it
               home = task_home[id];
               nx   = link_fwd[id];
               pv   = link_back[id];
               if (list_head[home] == id) list_head[home] = nx;
               else link_fwd[pv] = nx;
               if (list_tail[home] == id) list_tail[home] = pv;
               else link_back[nx] = pv;
               if (list_len[home] != 0) list_len[home] = list_len[home] - 1'b1;
               if (tasks_held != 0) tasks_held = tasks_held - 1'b1;
               task_queued[id] = 1'b0;
            end
         end
         CMD_PICK: begin
            if (list_len[active_list] == 0) begin
               // running list dry: swap roles, or report empty if both are dry
               if (list_len[~active_list] == 0) res.status = STATUS_EMPTY;
               else active_list = ~active_list;
            end
            if (res.status == STATUS_OK) res.picked_task = list_head[active_list];
         end
         default: begin
            // tick counts up only while below the allowance and always asks for a yield
            res.new_slice = (used < prio) ? used + 1'b1 : used;
            res.yielded   = 1'b1;
         end
      endcase
      res.queued_total = tasks_held;
      return res;
   endfunction

   // a task id that is, or is not, currently queued, if there is one
   function automatic task_type choose_task(logic want_queued);
      int       base;
      task_type id;
      base = $urandom_range(MAX_TASKS - 1);
      for (int k = 0; k < MAX_TASKS; k++) begin
         id = task_type'(base + k);
         if (task_queued[id] == want_queued) return id;
      end
      return task_type'($urandom_range(MAX_TASKS - 1));
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // drives one request at the falling edge and holds it until it is taken
   task automatic send_request(cmd_type cmd, task_type id, slice_type prio, slice_type used);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(99) < 35) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd          = cmd;
      req_task_id      = id;
      req_priority_req = prio;
      req_used_slice   = used;
      start            = 1'b1;
      do @(posedge clock); while (busy);
      // taken at this edge, so the shadow lists move now
      pending_outcomes.push_back(predict_outcome(cmd, id, prio, used));
      @(negedge clock);
   endtask

   // one random request; weights in percent, whatever is left over is ticks
   task automatic send_random(int enq_pct, int deq_pct, int pick_pct);
      int        roll;
      cmd_type   cmd;
      task_type  id;
      slice_type prio;
      slice_type used;
      roll = $urandom_range(99);
      if (roll < enq_pct) cmd = CMD_ENQUEUE;
      else if (roll < enq_pct + deq_pct) cmd = CMD_DEQUEUE;
      else if (roll < enq_pct + deq_pct + pick_pct) cmd = CMD_PICK;
      else cmd = CMD_TICK;
      prio = slice_type'($urandom_range(255));
      // keep the used slice near the allowance often, so the compare edge is hit
      case ($urandom_range(4))
         0: used = prio;
         1: used = prio - 1'b1;
         2: used = prio + 1'b1;
         default: used = slice_type'($urandom_range(255));
      endcase
      // mostly sensible ids, with a share that trips the error statuses
      if (cmd == CMD_ENQUEUE && $urandom_range(99) < 85) id = choose_task(1'b0);
      else if (cmd == CMD_DEQUEUE && $urandom_range(99) < 85) id = choose_task(1'b1);
      else id = task_type'($urandom_range(MAX_TASKS - 1));
      send_request(cmd, id, prio, used);
   endtask

   // response checker: every strobed response against the oldest prediction
   always @(posedge clock) begin
      sched_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unrequested response, status", rsp_status, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_picked_task !== want.picked_task)
               report_mismatch("picked_task", rsp_picked_task, want.picked_task);
            if (rsp_to_exhausted !== want.to_exhausted)
               report_mismatch("to_exhausted", rsp_to_exhausted, want.to_exhausted);
            if (rsp_new_slice !== want.new_slice)
               report_mismatch("new_slice", rsp_new_slice, want.new_slice);
            if (rsp_yielded !== want.yielded)
               report_mismatch("yielded", rsp_yielded, want.yielded);
            if (rsp_queued_total !== want.queued_total)
               report_mismatch("queued_total", rsp_queued_total, want.queued_total);
         end
      end
   end

   // watchdog: any request taken or response shown counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stalled_cycles <= 0;
      else stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // fresh block: pick with nothing queued, dequeue of absent tasks
   task automatic test_empty_scheduler();
      send_request(CMD_PICK, 6'd0, 8'd0, 8'd0);
      send_request(CMD_DEQUEUE, 6'd0, 8'd0, 8'd0);
      send_request(CMD_DEQUEUE, 6'd63, 8'd255, 8'd255);
   endtask

   // placement on either side of the slice compare, plus a double enqueue
   task automatic test_enqueue_placement();
      send_request(CMD_ENQUEUE, 6'd0, 8'd255, 8'd0);    // well inside allowance
      send_request(CMD_ENQUEUE, 6'd63, 8'd0, 8'd255);   // far past allowance
      send_request(CMD_ENQUEUE, 6'd5, 8'd7, 8'd7);      // exactly at allowance
      send_request(CMD_ENQUEUE, 6'd9, 8'd7, 8'd6);      // one short
      send_request(CMD_ENQUEUE, 6'd42, 8'd0, 8'd0);     // zero allowance
      send_request(CMD_ENQUEUE, 6'd0, 8'd1, 8'd0);      // already queued
   endtask

   // drain the running list, force the role swap, unlink middle and tail
   task automatic test_dequeue_and_swap();
      send_request(CMD_PICK, 6'd0, 8'd0, 8'd0);
      send_request(CMD_DEQUEUE, 6'd0, 8'd0, 8'd0);
      send_request(CMD_DEQUEUE, 6'd9, 8'd0, 8'd0);
      send_request(CMD_PICK, 6'd0, 8'd0, 8'd0);         // swap happens here
      send_request(CMD_DEQUEUE, 6'd5, 8'd0, 8'd0);      // middle of list
      send_request(CMD_DEQUEUE, 6'd42, 8'd0, 8'd0);     // tail of list
      send_request(CMD_PICK, 6'd0, 8'd0, 8'd0);
      send_request(CMD_DEQUEUE, 6'd63, 8'd0, 8'd0);
      send_request(CMD_DEQUEUE, 6'd63, 8'd0, 8'd0);     // no longer queued
      send_request(CMD_PICK, 6'd0, 8'd0, 8'd0);         // both lists empty
   endtask

   // tick below, at and above the allowance, including the top of the range
   task automatic test_tick_saturation();
      send_request(CMD_TICK, 6'd3, 8'd4, 8'd3);
      send_request(CMD_TICK, 6'd3, 8'd4, 8'd4);
      send_request(CMD_TICK, 6'd17, 8'd10, 8'd200);
      send_request(CMD_TICK, 6'd63, 8'd255, 8'd254);
      send_request(CMD_TICK, 6'd63, 8'd255, 8'd255);
      send_request(CMD_TICK, 6'd0, 8'd0, 8'd0);
   endtask

   // balanced mix with idling on the request side
   task automatic test_random_churn(int count);
      for (int n = 0; n < count; n++) send_random(30, 30, 20);
   endtask

   // alternate enqueue-heavy and dequeue-heavy stretches so the lists fill and empty
   task automatic test_fill_and_drain(int rounds, int count);
      for (int r = 0; r < rounds; r++) begin
         for (int n = 0; n < count; n++) send_random(65, 10, 15);
         for (int n = 0; n < count; n++) send_random(10, 65, 15);
      end
   endtask

   // requests back to back with no idling at all
   task automatic test_back_to_back(int count);
      idle_enable = 1'b0;
      for (int n = 0; n < count; n++) send_random(30, 30, 25);
      idle_enable = 1'b1;
   endtask

   initial begin
      clear_shadow();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_scheduler();
      test_enqueue_placement();
      test_dequeue_and_swap();
      test_tick_saturation();
      test_random_churn(500);
      test_fill_and_drain(2, 220);
      test_back_to_back(300);

      start = 1'b0;
      // the watchdog catches a response that never arrives
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/tqs_pkg.sv
rtl/tqs_ram.sv
rtl/tqs_slice_unit.sv
rtl/two_queue_slice_scheduler_unit.sv
dv/testbench.sv
